// ===== hw/rtl/pbrd_pkg.sv =====
// Shared types, constants and a helper function for the pulse beat rate detector.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package pbrd_pkg;

	// Field widths.
	localparam int IR_W    = 18;
	localparam int TIME_W  = 32;
	localparam int MS_W    = 16;
	localparam int BPM_W   = 8;
	localparam int Q_W     = 48;
	localparam int FRAC_W  = 16;
	localparam int WIDE_W  = Q_W + 2;
	localparam int K_W     = 16;

	// Stream payload widths, packed from the lowest bit up and padded to bytes.
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;
	localparam logic [CFG_IDX_W-1:0] CFG_FINGER_THR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_FLOOR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BPM_MIN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BPM_MAX    = 3'd5;

	// Register reset values.
	localparam logic [IR_W-1:0]  FINGER_THR_RST = 18'd25000;
	localparam logic [MS_W-1:0]  REFRACTORY_RST = 16'd350;
	localparam logic [MS_W-1:0]  TIMEOUT_RST    = 16'd5000;
	localparam logic [MS_W-1:0]  THR_FLOOR_RST  = 16'd100;
	localparam logic [BPM_W-1:0] BPM_MIN_RST    = 8'd50;
	localparam logic [BPM_W-1:0] BPM_MAX_RST    = 8'd150;

	// Q16 filter coefficients: 0.99, 0.15 and 0.85.
	localparam logic [K_W-1:0] K_099 = 16'd64881;
	localparam logic [K_W-1:0] K_015 = 16'd9830;
	localparam logic [K_W-1:0] K_085 = 16'd55706;

	// Rate conversion.
	localparam int QUO_W = 16;
	localparam logic [QUO_W-1:0] MS_PER_MIN = 16'd60000;

	// Rate averaging ring; the depth is a power of two.
	localparam int RING_DEPTH   = 4;
	localparam int RING_SHIFT   = $clog2(RING_DEPTH);
	localparam int SLOT_W       = (RING_SHIFT > 0) ? RING_SHIFT : 1;
	localparam int RING_TOTAL_W = BPM_W + RING_SHIFT;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);

	// Result codes.
	localparam logic [1:0] STATUS_FINGER = 2'd0;
	localparam logic [1:0] STATUS_NONE   = 2'd1;
	localparam logic [1:0] STATUS_FAULT  = 2'd2;
	localparam logic [1:0] ALERT_NONE    = 2'd0;
	localparam logic [1:0] ALERT_HIGH    = 2'd1;
	localparam logic [1:0] ALERT_LOW     = 2'd2;
	localparam logic [BPM_W-1:0] ALERT_HIGH_BPM = 8'd100;
	localparam logic [BPM_W-1:0] ALERT_LOW_BPM  = 8'd60;

	typedef logic signed [Q_W-1:0]    q16_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	// Clamps a widened sum back to the signed 48-bit range.
	function automatic q16_t sat48(input wide_t v);
		wide_t hi;
		wide_t lo;
		hi = WIDE_W'({1'b0, {(Q_W-1){1'b1}}});
		lo = -hi - WIDE_W'(1);
		if (v > hi) begin
			return q16_t'(hi);
		end else if (v < lo) begin
			return q16_t'(lo);
		end else begin
			return q16_t'(v);
		end
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pbrd_mul.sv =====
// Shared Q16 coefficient multiplier with round-half-away-from-zero, three stages.
// Depends on pbrd_pkg.
`default_nettype none

module pbrd_mul (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire pbrd_pkg::q16_t                 a,
	input  wire logic [pbrd_pkg::K_W-1:0]       k,
	output logic                                done,
	output pbrd_pkg::q16_t                      result
);

	localparam int PROD_W = pbrd_pkg::Q_W + pbrd_pkg::K_W;

	logic                          v_s1, v_s2, v_s3;
	logic                          neg_s1, neg_s2;
	logic [pbrd_pkg::Q_W-1:0]      mag_s1;
	logic [pbrd_pkg::K_W-1:0]      k_s1;
	logic [PROD_W-1:0]             prod_s2;
	logic [PROD_W-1:0]             rnd;
	logic [pbrd_pkg::Q_W-1:0]      mag_rnd;
	pbrd_pkg::q16_t                res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1  <= a[pbrd_pkg::Q_W-1];
		mag_s1  <= a[pbrd_pkg::Q_W-1] ? (~a + pbrd_pkg::Q_W'(1)) : a;
		k_s1    <= k;
		neg_s2  <= neg_s1;
		prod_s2 <= PROD_W'(mag_s1) * PROD_W'(k_s1);
		res_s3  <= neg_s2 ? -$signed(mag_rnd) : $signed(mag_rnd);
	end

	assign rnd     = prod_s2 + PROD_W'(32768);
	assign mag_rnd = rnd[pbrd_pkg::FRAC_W +: pbrd_pkg::Q_W];

	assign done   = v_s3;
	assign result = res_s3;

endmodule

`default_nettype wire

// ===== hw/rtl/pbrd_div.sv =====
// Restoring divider for 60000 / interval, one quotient bit per cycle.
// Depends on pbrd_pkg.
`default_nettype none

module pbrd_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [pbrd_pkg::TIME_W-1:0]       divisor,
	output logic                                   done,
	output logic [pbrd_pkg::QUO_W-1:0]             quotient
);

	localparam int CNT_W = $clog2(pbrd_pkg::QUO_W);

	logic                          busy_q, done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [pbrd_pkg::QUO_W-1:0]    rem_q, quo_q;
	logic [pbrd_pkg::TIME_W-1:0]   div_q;
	logic [pbrd_pkg::QUO_W:0]      trial;
	logic                          fits;

	assign trial = {rem_q, pbrd_pkg::MS_PER_MIN[~cnt_q]};
	assign fits  = pbrd_pkg::TIME_W'(trial) >= div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(pbrd_pkg::QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? pbrd_pkg::QUO_W'(trial - pbrd_pkg::QUO_W'(div_q))
			              : pbrd_pkg::QUO_W'(trial);
			quo_q <= {quo_q[pbrd_pkg::QUO_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pulse_beat_rate_detector_unit.sv =====
// Top level of the pulse beat rate detector: sequencer, filter state and rate ring.
// Depends on pbrd_pkg, pbrd_mul and pbrd_div.
//
// Usage: each input item on the s_ stream carries one IR sample and a millisecond
// timestamp. Each item yields exactly one result item on the m_ stream with the
// averaged rate, beat flags, finger status and rate alert.
// For a finger sample, a sequencer drives one shared three-stage Q16 multiplier
// through four products (DC removal, low-pass input, low-pass feedback, threshold
// decay) and then, on a beat, a restoring divider for the beat rate. A sensor
// fault goes straight to the output register; a no-finger sample first resets
// the filters and checks the timeout. s_tready is high only while the sequencer
// is idle, so a new item waits until the sequencer is through with the last one.
// The result sits in an output register: the next item is accepted while it
// waits, and the sequencer holds a finished result until m_tready frees the
// register. Reset loads the register defaults, clears the filters and the ring,
// and sets the peak threshold to its floor. Configuration writes are taken at
// any edge with cfg_we high and are meant to happen only while idle.
`default_nettype none

module pulse_beat_rate_detector_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// tdata: ir_sample [17:0], now_ms [49:18], zero fill [55:50]
	input  wire logic [pbrd_pkg::IN_DATA_W-1:0]       s_tdata,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// tdata: avg_bpm [7:0], beat_seen [8], beat_stored [9], status [11:10],
	// alert [13:12], zero fill [15:14]
	output logic [pbrd_pkg::OUT_DATA_W-1:0]           m_tdata,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	input  wire logic                                 cfg_we,
	input  wire logic [pbrd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [pbrd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_CHECK = 10'b00_0000_0010,
		ST_MISS  = 10'b00_0000_0100,
		ST_MWAIT = 10'b00_0000_1000,
		ST_AC    = 10'b00_0001_0000,
		ST_BEAT  = 10'b00_0010_0000,
		ST_DIV   = 10'b00_0100_0000,
		ST_RING  = 10'b00_1000_0000,
		ST_TMO   = 10'b01_0000_0000,
		ST_OUT   = 10'b10_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		OP_DC = 2'd0,
		OP_AC = 2'd1,
		OP_LP = 2'd2,
		OP_PT = 2'd3
	} mop_t;

	state_t state_q;
	mop_t   mop_q;

	logic [pbrd_pkg::IR_W-1:0]    finger_thr_q;
	logic [pbrd_pkg::MS_W-1:0]    refractory_q, timeout_q, thr_floor_q;
	logic [pbrd_pkg::BPM_W-1:0]   bpm_min_q, bpm_max_q;

	logic [pbrd_pkg::IR_W-1:0]    ir_q;
	logic [pbrd_pkg::TIME_W-1:0]  now_q, last_q;
	pbrd_pkg::q16_t               dc_q, lp_q, pt_q, tmp_q, acc_q;
	logic [pbrd_pkg::BPM_W-1:0]   ring_q [pbrd_pkg::RING_DEPTH];
	logic [pbrd_pkg::SLOT_W-1:0]  slot_q;
	logic [pbrd_pkg::RING_TOTAL_W-1:0] total_q;
	logic [pbrd_pkg::BPM_W-1:0]   held_q;
	logic                         seen_q, stored_q;
	logic [1:0]                   status_q;

	logic [pbrd_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic                            m_tvalid_q;

	logic                         mul_start, mul_done;
	pbrd_pkg::q16_t               mul_a, mul_res;
	logic [pbrd_pkg::K_W-1:0]     mul_k;
	logic                         div_start, div_done;
	logic [pbrd_pkg::QUO_W-1:0]   div_quo;

	logic [pbrd_pkg::TIME_W-1:0]  delta;
	pbrd_pkg::q16_t               floor_q16;
	logic [pbrd_pkg::RING_TOTAL_W-1:0] total_new;
	logic                         rate_ok;
	logic [1:0]                   alert;
	logic                         out_free;

	assign delta     = now_q - last_q;
	assign floor_q16 = {{(pbrd_pkg::Q_W - pbrd_pkg::MS_W - pbrd_pkg::FRAC_W){1'b0}},
	                    thr_floor_q, {pbrd_pkg::FRAC_W{1'b0}}};
	assign total_new = total_q - pbrd_pkg::RING_TOTAL_W'(ring_q[slot_q])
	                   + pbrd_pkg::RING_TOTAL_W'(div_quo[pbrd_pkg::BPM_W-1:0]);
	assign rate_ok   = (div_quo > pbrd_pkg::QUO_W'(bpm_min_q))
	                   && (div_quo < pbrd_pkg::QUO_W'(bpm_max_q));
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		if (held_q > pbrd_pkg::ALERT_HIGH_BPM) begin
			alert = pbrd_pkg::ALERT_HIGH;
		end else if (held_q != '0 && held_q < pbrd_pkg::ALERT_LOW_BPM) begin
			alert = pbrd_pkg::ALERT_LOW;
		end else begin
			alert = pbrd_pkg::ALERT_NONE;
		end
	end

	always_comb begin
		case (mop_q)
			OP_DC: begin
				mul_a = dc_q;
				mul_k = pbrd_pkg::K_099;
			end
			OP_AC: begin
				mul_a = tmp_q;
				mul_k = pbrd_pkg::K_015;
			end
			OP_LP: begin
				mul_a = lp_q;
				mul_k = pbrd_pkg::K_085;
			end
			default: begin
				mul_a = pt_q;
				mul_k = pbrd_pkg::K_099;
			end
		endcase
	end

	assign mul_start = (state_q == ST_MISS);
	assign div_start = (state_q == ST_BEAT) && (lp_q > pt_q)
	                   && (delta > pbrd_pkg::TIME_W'(refractory_q));

	pbrd_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.k      (mul_k),
		.done   (mul_done),
		.result (mul_res)
	);

	pbrd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (delta),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finger_thr_q <= pbrd_pkg::FINGER_THR_RST;
			refractory_q <= pbrd_pkg::REFRACTORY_RST;
			timeout_q    <= pbrd_pkg::TIMEOUT_RST;
			thr_floor_q  <= pbrd_pkg::THR_FLOOR_RST;
			bpm_min_q    <= pbrd_pkg::BPM_MIN_RST;
			bpm_max_q    <= pbrd_pkg::BPM_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pbrd_pkg::CFG_FINGER_THR: finger_thr_q <= cfg_wdata;
				pbrd_pkg::CFG_REFRACTORY: refractory_q <= cfg_wdata[pbrd_pkg::MS_W-1:0];
				pbrd_pkg::CFG_TIMEOUT:    timeout_q    <= cfg_wdata[pbrd_pkg::MS_W-1:0];
				pbrd_pkg::CFG_THR_FLOOR:  thr_floor_q  <= cfg_wdata[pbrd_pkg::MS_W-1:0];
				pbrd_pkg::CFG_BPM_MIN:    bpm_min_q    <= cfg_wdata[pbrd_pkg::BPM_W-1:0];
				pbrd_pkg::CFG_BPM_MAX:    bpm_max_q    <= cfg_wdata[pbrd_pkg::BPM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mop_q      <= OP_DC;
			dc_q       <= '0;
			lp_q       <= '0;
			pt_q       <= pbrd_pkg::q16_t'(pbrd_pkg::THR_FLOOR_RST) <<< pbrd_pkg::FRAC_W;
			last_q     <= '0;
			slot_q     <= '0;
			total_q    <= '0;
			held_q     <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < pbrd_pkg::RING_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (ir_q == '0) begin
						held_q  <= '0;
						state_q <= ST_OUT;
					end else if (ir_q > finger_thr_q) begin
						mop_q   <= OP_DC;
						state_q <= ST_MISS;
					end else begin
						held_q  <= '0;
						dc_q    <= '0;
						lp_q    <= '0;
						pt_q    <= floor_q16;
						state_q <= ST_TMO;
					end
				end
				ST_MISS: begin
					state_q <= ST_MWAIT;
				end
				ST_MWAIT: begin
					if (mul_done) begin
						case (mop_q)
							OP_DC: begin
								dc_q    <= pbrd_pkg::sat48(
									pbrd_pkg::wide_t'({ir_q, {pbrd_pkg::FRAC_W{1'b0}}})
									+ pbrd_pkg::wide_t'(mul_res));
								state_q <= ST_AC;
							end
							OP_AC: begin
								mop_q   <= OP_LP;
								state_q <= ST_MISS;
							end
							OP_LP: begin
								lp_q    <= pbrd_pkg::sat48(pbrd_pkg::wide_t'(acc_q)
									+ pbrd_pkg::wide_t'(mul_res));
								mop_q   <= OP_PT;
								state_q <= ST_MISS;
							end
							default: begin
								pt_q    <= (mul_res < floor_q16) ? floor_q16 : mul_res;
								state_q <= ST_BEAT;
							end
						endcase
					end
				end
				ST_AC: begin
					mop_q   <= OP_AC;
					state_q <= ST_MISS;
				end
				ST_BEAT: begin
					if (div_start) begin
						pt_q    <= lp_q;
						last_q  <= now_q;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_TMO;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_RING;
					end
				end
				ST_RING: begin
					if (rate_ok) begin
						ring_q[slot_q] <= div_quo[pbrd_pkg::BPM_W-1:0];
						total_q        <= total_new;
						held_q         <= total_new[pbrd_pkg::RING_SHIFT +: pbrd_pkg::BPM_W];
						slot_q         <= (slot_q == pbrd_pkg::LAST_SLOT) ? '0
						                  : slot_q + pbrd_pkg::SLOT_W'(1);
					end
					state_q <= ST_TMO;
				end
				ST_TMO: begin
					if (delta > pbrd_pkg::TIME_W'(timeout_q)) begin
						held_q <= '0;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			ir_q  <= s_tdata[pbrd_pkg::IR_W-1:0];
			now_q <= s_tdata[pbrd_pkg::IR_W +: pbrd_pkg::TIME_W];
		end
		case (state_q)
			ST_CHECK: begin
				seen_q   <= 1'b0;
				stored_q <= 1'b0;
				if (ir_q == '0) begin
					status_q <= pbrd_pkg::STATUS_FAULT;
				end else if (ir_q > finger_thr_q) begin
					status_q <= pbrd_pkg::STATUS_FINGER;
				end else begin
					status_q <= pbrd_pkg::STATUS_NONE;
				end
			end
			ST_MWAIT: begin
				if (mul_done && mop_q == OP_DC) begin
					tmp_q <= dc_q;
				end
				if (mul_done && mop_q == OP_AC) begin
					acc_q <= mul_res;
				end
			end
			ST_AC: begin
				tmp_q <= pbrd_pkg::sat48(pbrd_pkg::wide_t'(dc_q) - pbrd_pkg::wide_t'(tmp_q));
			end
			ST_BEAT: begin
				seen_q <= div_start;
			end
			ST_RING: begin
				stored_q <= rate_ok;
			end
			ST_OUT: begin
				if (out_free) begin
					m_tdata_q <= {2'b00, alert, status_q, stored_q, seen_q, held_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_stored_needs_seen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[9] && !m_tdata[8]))
		else $error("beat stored without a beat seen");

	a_fault_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[11:10] == pbrd_pkg::STATUS_FAULT)
		|-> (m_tdata[7:0] == '0 && m_tdata[13:12] == pbrd_pkg::ALERT_NONE && !m_tdata[8]))
		else $error("sensor fault result carries a rate");

	a_high_alert: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[7:0] > pbrd_pkg::ALERT_HIGH_BPM)
		|-> m_tdata[13:12] == pbrd_pkg::ALERT_HIGH)
		else $error("high rate without high alert");

	a_div_in_place: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside its sequencer step");

endmodule

`default_nettype wire
